[hw/rtl/bde_pkg.sv]
// Shared types and constants for the button debounce event detector.
`default_nettype none

package bde_pkg;

    localparam int MAX_BTN    = 4;
    localparam int TIME_W     = 32;
    localparam int LONG_W     = 16;
    localparam int DB_W       = 8;
    localparam int EVT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DB_W-1:0]   DEBOUNCE_RESET = 8'd20;
    localparam logic [LONG_W-1:0] LONG_RESET     = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG3    = 3'd4;

    localparam logic [EVT_W-1:0] EVT_PRESSED  = 4'b0001;
    localparam logic [EVT_W-1:0] EVT_RELEASED = 4'b0010;
    localparam logic [EVT_W-1:0] EVT_CLICK    = 4'b0100;
    localparam logic [EVT_W-1:0] EVT_LONG     = 4'b1000;

    typedef struct packed {
        logic              pressed;
        logic              evt;
        logic [EVT_W-1:0]  events;
        logic [TIME_W-1:0] ptime;
    } t_chan_stat;

endpackage

`default_nettype wire

[hw/rtl/button_debounce_event_detector.sv]
// Top level: shared debounce, per-button event tracking and per-tick report.
//
//   channel | direction | handshake                  | beat
//   in      | sink      | i_in_valid / o_in_stall    | pin_levels, read_channel, read_clear
//   out     | source    | o_out_valid / i_out_stall  | mask, count, events, time, notify
//   cfg     | sink      | i_cfg_valid / o_cfg_ready  | index, data
//
// One beat per cycle sustained while the output is not stalled; a result passes
// through the input register, then the update logic into the output register.
// Synchronous active-low reset; no clearing pass, the block takes beats right away.
// Output stall holds the output register; the input register absorbs one more beat
// before o_in_stall rises.
`default_nettype none

module button_debounce_event_detector #(
    parameter int CHANNELS = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire logic [3:0]                        i_pin_levels,
    input  wire logic [1:0]                        i_read_channel,
    input  wire logic                              i_read_clear,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      logic [3:0]                        o_pressed_mask,
    output      logic [2:0]                        o_pressed_count,
    output      logic [3:0]                        o_channel_events,
    output      logic [31:0]                       o_pressed_time,
    output      logic                              o_notify,
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic [bde_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bde_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NCH = (CHANNELS < bde_pkg::MAX_BTN) ? CHANNELS : bde_pkg::MAX_BTN;

    logic                        r_in_valid;
    logic [3:0]                  r_levels;
    logic [1:0]                  r_ch;
    logic                        r_clr;

    logic [bde_pkg::TIME_W-1:0]  r_tick, n_tick;
    logic [3:0]                  r_raw_last;
    logic [bde_pkg::DB_W-1:0]    r_db_left, n_db_left;
    logic                        r_upd_pend;
    logic                        upd;
    logic [bde_pkg::DB_W-1:0]    r_db_ticks;
    logic [bde_pkg::LONG_W-1:0]  r_hold_limit [bde_pkg::MAX_BTN];

    logic                        r_out_valid;
    logic [3:0]                  r_mask;
    logic [2:0]                  r_count;
    logic [3:0]                  r_events;
    logic [31:0]                 r_ptime;
    logic                        r_notify;

    logic                        out_ready;
    logic                        adv;
    bde_pkg::t_chan_stat         stat [bde_pkg::MAX_BTN];
    logic [3:0]                  mask;
    logic [2:0]                  count;
    logic                        notify;
    logic [1:0]                  cfg_ch;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign o_cfg_ready = 1'b1;

    assign n_tick = r_tick + bde_pkg::TIME_W'(1);

    always_comb begin
        n_db_left = r_db_left;
        upd       = r_upd_pend;
        if (r_levels != r_raw_last) begin
            if (r_db_ticks == '0) begin
                n_db_left = '0;
                upd       = 1'b1;
            end else begin
                n_db_left = r_db_ticks;
            end
        end else if (r_db_left != '0) begin
            n_db_left = r_db_left - bde_pkg::DB_W'(1);
            if (n_db_left == '0) begin
                upd = 1'b1;
            end
        end
    end

    for (genvar c = 0; c < bde_pkg::MAX_BTN; c++) begin : g_chan
        if (c < NCH) begin : g_on
            bde_chan u_chan (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_adv        (adv),
                .i_tick       (n_tick),
                .i_upd        (upd),
                .i_level      (r_levels[c]),
                .i_hold_limit (r_hold_limit[c]),
                .i_clr        (r_clr && (r_ch == 2'(c))),
                .o_stat       (stat[c])
            );
        end else begin : g_off
            assign stat[c] = '0;
        end
    end

    always_comb begin
        count  = '0;
        notify = 1'b0;
        for (int c = 0; c < bde_pkg::MAX_BTN; c++) begin
            mask[c] = stat[c].pressed;
            count   = count + 3'(stat[c].pressed);
            notify  = notify | stat[c].evt;
        end
    end

    assign cfg_ch = 2'(i_cfg_index - bde_pkg::REG_LONG0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_ticks <= bde_pkg::DEBOUNCE_RESET;
            for (int c = 0; c < bde_pkg::MAX_BTN; c++) begin
                r_hold_limit[c] <= bde_pkg::LONG_RESET;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bde_pkg::REG_DEBOUNCE) begin
                r_db_ticks <= i_cfg_data[bde_pkg::DB_W-1:0];
            end else if (i_cfg_index >= bde_pkg::REG_LONG0 &&
                         i_cfg_index <= bde_pkg::REG_LONG3 && (32'(cfg_ch) < NCH)) begin
                r_hold_limit[cfg_ch] <= i_cfg_data[bde_pkg::LONG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_levels <= i_pin_levels;
            r_ch     <= i_read_channel;
            r_clr    <= i_read_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_raw_last <= '0;
            r_db_left  <= '0;
            r_upd_pend <= 1'b1;
        end else if (adv) begin
            r_tick     <= n_tick;
            r_raw_last <= r_levels;
            r_db_left  <= n_db_left;
            r_upd_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mask   <= mask;
            r_count  <= count;
            r_events <= stat[r_ch].events;
            r_ptime  <= stat[r_ch].ptime;
            r_notify <= notify;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pressed_mask   = r_mask;
    assign o_pressed_count  = r_count;
    assign o_channel_events = r_events;
    assign o_pressed_time   = r_ptime;
    assign o_notify         = r_notify;

endmodule

`default_nettype wire

[hw/rtl/bde_chan.sv]
// Per-button state: long-press countdown, press timestamps and event flags.
`default_nettype none

module bde_chan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic [bde_pkg::TIME_W-1:0]  i_tick,
    input  wire logic                        i_upd,
    input  wire logic                        i_level,
    input  wire logic [bde_pkg::LONG_W-1:0]  i_hold_limit,
    input  wire logic                        i_clr,
    output bde_pkg::t_chan_stat              o_stat
);

    logic                        r_pressed, n_pressed;
    logic                        r_armed, n_armed;
    logic                        r_done, n_done;
    logic [bde_pkg::LONG_W-1:0]  r_left, n_left;
    logic [bde_pkg::TIME_W-1:0]  r_start, n_start;
    logic [bde_pkg::TIME_W-1:0]  r_end, n_end;
    logic [bde_pkg::EVT_W-1:0]   r_flags, n_flags;
    logic [bde_pkg::EVT_W-1:0]   flags_rep;
    logic                        long_evt;
    logic                        chg;

    always_comb begin
        n_pressed = r_pressed;
        n_armed   = r_armed;
        n_done    = r_done;
        n_left    = r_left;
        n_start   = r_start;
        n_end     = r_end;
        flags_rep = r_flags;
        long_evt  = 1'b0;
        chg       = 1'b0;

        // long-press countdown runs before the debounced update
        if (r_armed) begin
            if (r_left <= bde_pkg::LONG_W'(1)) begin
                n_armed = 1'b0;
                n_left  = '0;
                if (r_pressed) begin
                    n_done    = 1'b1;
                    flags_rep = flags_rep | bde_pkg::EVT_LONG;
                    long_evt  = 1'b1;
                end
            end else begin
                n_left = r_left - bde_pkg::LONG_W'(1);
            end
        end

        if (i_upd && (i_level != r_pressed)) begin
            chg = 1'b1;
            if (i_level) begin
                n_start   = i_tick;
                n_done    = 1'b0;
                flags_rep = flags_rep | bde_pkg::EVT_PRESSED;
                n_left    = i_hold_limit;
                n_armed   = 1'b1;
                n_pressed = 1'b1;
            end else begin
                n_end   = i_tick;
                n_armed = 1'b0;
                n_left  = '0;
                if (n_done) begin
                    flags_rep = flags_rep | bde_pkg::EVT_RELEASED;
                end else begin
                    flags_rep = flags_rep | bde_pkg::EVT_RELEASED | bde_pkg::EVT_CLICK;
                end
                n_pressed = 1'b0;
            end
        end

        n_flags = i_clr ? '0 : flags_rep;

        o_stat.pressed = n_pressed;
        o_stat.evt     = long_evt | chg;
        o_stat.events  = flags_rep;
        o_stat.ptime   = n_pressed ? (i_tick - n_start) : (n_end - n_start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_armed   <= 1'b0;
            r_done    <= 1'b0;
            r_left    <= '0;
            r_start   <= '0;
            r_end     <= '0;
            r_flags   <= '0;
        end else if (i_adv) begin
            r_pressed <= n_pressed;
            r_armed   <= n_armed;
            r_done    <= n_done;
            r_left    <= n_left;
            r_start   <= n_start;
            r_end     <= n_end;
            r_flags   <= n_flags;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bde_check.sv]
// Port-level checks for the button debounce event detector, with bind.
`default_nettype none

module bde_check (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [3:0]                        o_pressed_mask,
    input wire logic [2:0]                        o_pressed_count,
    input wire logic [3:0]                        o_channel_events,
    input wire logic [31:0]                       o_pressed_time,
    input wire logic                              o_notify
);

    // held result beat stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pressed_time) &&
        $stable(o_channel_events) && $stable(o_pressed_mask) && $stable(o_notify))
        else $error("result beat changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_pressed_count) == $countones(o_pressed_mask)))
        else $error("pressed count does not match mask");

    a_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_channel_events[2] |-> o_channel_events[1])
        else $error("click without release");

    // input only backs up when the output side is blocked
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

endmodule

bind button_debounce_event_detector bde_check u_bde_check (.*);

`default_nettype wire

[tb/bde_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the button debounce event detector: predicts every report beat and checks it.
module bde_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic [3:0]                      i_pin_levels,
    input  logic [1:0]                      i_read_channel,
    input  logic                            i_read_clear,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [3:0]                      o_pressed_mask,
    input  logic [2:0]                      o_pressed_count,
    input  logic [3:0]                      o_channel_events,
    input  logic [31:0]                     o_pressed_time,
    input  logic                            o_notify,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [bde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bde_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_errors,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_clicks,
    output int                              o_longs
);

    typedef struct packed {
        logic [bde_pkg::MAX_BTN-1:0] mask;
        logic [2:0]                  count;
        logic [bde_pkg::EVT_W-1:0]   events;
        logic [bde_pkg::TIME_W-1:0]  ptime;
        logic                        notify;
    } t_tick_report;

    t_tick_report pending_reports[$];

    logic [bde_pkg::DB_W-1:0]    db_ticks;
    logic [bde_pkg::LONG_W-1:0]  hold_limit [bde_pkg::MAX_BTN];
    logic [bde_pkg::MAX_BTN-1:0] raw_last;
    logic [bde_pkg::DB_W-1:0]    db_left;
    logic                        upd_pending;
    logic [bde_pkg::MAX_BTN-1:0] deb_pressed;
    logic [bde_pkg::MAX_BTN-1:0] long_done;
    logic [bde_pkg::MAX_BTN-1:0] long_armed;
    logic [bde_pkg::LONG_W-1:0]  long_left [bde_pkg::MAX_BTN];
    logic [bde_pkg::TIME_W-1:0]  press_start [bde_pkg::MAX_BTN];
    logic [bde_pkg::TIME_W-1:0]  press_end [bde_pkg::MAX_BTN];
    logic [bde_pkg::EVT_W-1:0]   evt_flags [bde_pkg::MAX_BTN];
    logic [bde_pkg::TIME_W-1:0]  tick_now;

    int fail_n    = 0;
    int checked_n = 0;
    int clicks_n  = 0;
    int longs_n   = 0;
    int waiting_n = 0;

    assign o_errors      = fail_n;
    assign o_outstanding = waiting_n;
    assign o_checked     = checked_n;
    assign o_clicks      = clicks_n;
    assign o_longs       = longs_n;

    task automatic advance_tick(input logic [3:0] lv, input logic [1:0] ch, input logic clr);
        t_tick_report r;
        logic nt;
        int b;
        nt = 1'b0;
        tick_now = tick_now + bde_pkg::TIME_W'(1);

        for (b = 0; b < bde_pkg::MAX_BTN; b++) begin
            if (long_armed[b]) begin
                if (long_left[b] <= bde_pkg::LONG_W'(1)) begin
                    long_armed[b] = 1'b0;
                    long_left[b] = '0;
                    if (deb_pressed[b]) begin
                        long_done[b] = 1'b1;
                        evt_flags[b] |= bde_pkg::EVT_LONG;
                        nt = 1'b1;
                        longs_n++;
                    end
                end else begin
                    long_left[b] = long_left[b] - bde_pkg::LONG_W'(1);
                end
            end
        end

        if (lv != raw_last) begin
            raw_last = lv;
            if (db_ticks == '0) begin
                db_left = '0;
                upd_pending = 1'b1;
            end else begin
                db_left = db_ticks;
            end
        end else if (db_left != '0) begin
            db_left = db_left - bde_pkg::DB_W'(1);
            if (db_left == '0) upd_pending = 1'b1;
        end

        if (upd_pending) begin
            upd_pending = 1'b0;
            for (b = 0; b < bde_pkg::MAX_BTN; b++) begin
                if (lv[b] != deb_pressed[b]) begin
                    if (lv[b]) begin
                        press_start[b] = tick_now;
                        long_done[b] = 1'b0;
                        evt_flags[b] |= bde_pkg::EVT_PRESSED;
                        long_left[b] = hold_limit[b];
                        long_armed[b] = 1'b1;
                        deb_pressed[b] = 1'b1;
                    end else begin
                        press_end[b] = tick_now;
                        long_armed[b] = 1'b0;
                        long_left[b] = '0;
                        if (long_done[b]) begin
                            evt_flags[b] |= bde_pkg::EVT_RELEASED;
                        end else begin
                            evt_flags[b] |= bde_pkg::EVT_RELEASED | bde_pkg::EVT_CLICK;
                            clicks_n++;
                        end
                        deb_pressed[b] = 1'b0;
                    end
                    nt = 1'b1;
                end
            end
        end

        r.mask   = deb_pressed;
        r.count  = 3'($countones(deb_pressed));
        r.events = evt_flags[ch];
        r.ptime  = deb_pressed[ch] ? tick_now - press_start[ch]
                                   : press_end[ch] - press_start[ch];
        r.notify = nt;
        if (clr) evt_flags[ch] = '0;
        pending_reports.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_n++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_report due;
        if (!i_rst_n) begin
            db_ticks    = bde_pkg::DEBOUNCE_RESET;
            raw_last    = '0;
            db_left     = '0;
            upd_pending = 1'b1;
            deb_pressed = '0;
            long_done   = '0;
            long_armed  = '0;
            tick_now    = '0;
            for (int b = 0; b < bde_pkg::MAX_BTN; b++) begin
                hold_limit[b]  = bde_pkg::LONG_RESET;
                long_left[b]   = '0;
                press_start[b] = '0;
                press_end[b]   = '0;
                evt_flags[b]   = '0;
            end
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bde_pkg::REG_DEBOUNCE) begin
                    db_ticks = i_cfg_data[bde_pkg::DB_W-1:0];
                end else if (i_cfg_index >= bde_pkg::REG_LONG0 &&
                             i_cfg_index <= bde_pkg::REG_LONG3) begin
                    hold_limit[2'(i_cfg_index - bde_pkg::REG_LONG0)] =
                        i_cfg_data[bde_pkg::LONG_W-1:0];
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_tick(i_pin_levels, i_read_channel, i_read_clear);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("report beat with no tick outstanding");
                    fail_n++;
                end else begin
                    due = pending_reports.pop_front();
                    check_field("pressed_mask", 32'(due.mask), 32'(o_pressed_mask));
                    check_field("pressed_count", 32'(due.count), 32'(o_pressed_count));
                    check_field("channel_events", 32'(due.events), 32'(o_channel_events));
                    check_field("pressed_time", due.ptime, o_pressed_time);
                    check_field("notify", 32'(due.notify), 32'(o_notify));
                    checked_n++;
                end
            end
        end
        waiting_n = pending_reports.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top: drives button ticks, timing registers and output stalls, and reports the verdict.
module tb_top;

    localparam int LIMIT        = 400_000;
    localparam int RANDOM_TICKS = 1750;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [3:0]                     i_pin_levels;
    logic [1:0]                     i_read_channel;
    logic                           i_read_clear;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [3:0]                     o_pressed_mask;
    logic [2:0]                     o_pressed_count;
    logic [3:0]                     o_channel_events;
    logic [31:0]                    o_pressed_time;
    logic                           o_notify;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bde_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bde_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int errors_n;
    int outstanding_n;
    int checked_n;
    int clicks_n;
    int longs_n;

    int         cycles     = 0;
    int         sent       = 0;
    int         burst_left = 0;
    int         phases     = 0;
    int         stall_cnt  = 0;
    int         stall_mode = 0;
    logic [3:0] levels_now = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    button_debounce_event_detector u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pin_levels     (i_pin_levels),
        .i_read_channel   (i_read_channel),
        .i_read_clear     (i_read_clear),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pressed_mask   (o_pressed_mask),
        .o_pressed_count  (o_pressed_count),
        .o_channel_events (o_channel_events),
        .o_pressed_time   (o_pressed_time),
        .o_notify         (o_notify),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    bde_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pin_levels     (i_pin_levels),
        .i_read_channel   (i_read_channel),
        .i_read_clear     (i_read_clear),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pressed_mask   (o_pressed_mask),
        .o_pressed_count  (o_pressed_count),
        .o_channel_events (o_channel_events),
        .o_pressed_time   (o_pressed_time),
        .o_notify         (o_notify),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors_n),
        .o_outstanding    (outstanding_n),
        .o_checked        (checked_n),
        .o_clicks         (clicks_n),
        .o_longs          (longs_n)
    );

    // output stall: random modes held for random stretches
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt  = $urandom_range(16, 200);
        end
        stall_cnt--;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_cnt[3];
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one tick beat; returns after acceptance, at times after a random idle gap
    task automatic send_tick(input logic [3:0] lv, input logic [1:0] ch, input logic clr);
        i_in_valid     <= 1'b1;
        i_pin_levels   <= lv;
        i_read_channel <= ch;
        i_read_clear   <= clr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_level(input logic [3:0] lv);
        send_tick(lv, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding_n != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [bde_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bde_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timing(input logic [bde_pkg::DB_W-1:0] db,
                              input logic [bde_pkg::MAX_BTN-1:0][bde_pkg::LONG_W-1:0] lt);
        drain();
        // upper data byte is don't-care for the debounce register
        cfg_write(bde_pkg::REG_DEBOUNCE,
                  {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, db});
        for (int c = 0; c < bde_pkg::MAX_BTN; c++) begin
            cfg_write(bde_pkg::CFG_IDX_W'(bde_pkg::REG_LONG0 + c), lt[c]);
        end
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(bde_pkg::CFG_IDX_W'(bde_pkg::REG_LONG3 + $urandom_range(1, 3)),
                      16'($urandom));
        end
        phases++;
    endtask

    // press/release gestures with bounce, glitches and some raw noise
    task automatic play_phase(input int db, input int budget);
        int done_n;
        int hold;
        int hold_back;
        int k;
        logic [3:0] nxt;
        done_n = 0;
        while (done_n < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    if ($urandom_range(0, 3) == 0) nxt = levels_now ^ 4'($urandom_range(1, 15));
                    else nxt = levels_now ^ 4'(1 << $urandom_range(0, 3));
                    k = (db > 1) ? $urandom_range(0, 3) : 0;
                    repeat (k) begin
                        send_level(nxt);
                        send_level(levels_now);
                    end
                    hold = db + $urandom_range(1, 40);
                    repeat (hold) send_level(nxt);
                    levels_now = nxt;
                    done_n += hold + 2 * k;
                end
                7, 8: begin
                    hold = (db > 1) ? $urandom_range(1, (db > 8) ? 8 : db - 1) : 1;
                    nxt = 4'($urandom_range(0, 15));
                    repeat (hold) send_level(nxt);
                    hold_back = db + $urandom_range(1, 5);
                    repeat (hold_back) send_level(levels_now);
                    done_n += hold + hold_back;
                end
                default: begin
                    hold = $urandom_range(1, 8);
                    repeat (hold) begin
                        levels_now = 4'($urandom_range(0, 15));
                        send_level(levels_now);
                    end
                    done_n += hold;
                end
            endcase
        end
    endtask

    initial begin
        int base;
        int p;
        int budget;
        logic [bde_pkg::DB_W-1:0] db;
        logic [bde_pkg::MAX_BTN-1:0][bde_pkg::LONG_W-1:0] lt;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_pin_levels   = '0;
        i_read_channel = '0;
        i_read_clear   = 1'b0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first tick after reset takes the levels at once
        send_tick(4'b1010, 2'd1, 1'b0);
        send_tick(4'b1010, 2'd3, 1'b1);

        // zero debounce; long times 0, 1, max and 2
        lt[0] = 16'd0;
        lt[1] = 16'd1;
        lt[2] = 16'hFFFF;
        lt[3] = 16'd2;
        set_timing(8'd0, lt);
        send_tick(4'b1011, 2'd0, 1'b0);
        send_tick(4'b1011, 2'd0, 1'b0);
        send_tick(4'b0000, 2'd0, 1'b1);
        send_tick(4'b0000, 2'd1, 1'b1);
        // long expiry on the release tick
        send_tick(4'b0010, 2'd1, 1'b0);
        send_tick(4'b0000, 2'd1, 1'b1);
        send_tick(4'b1000, 2'd3, 1'b0);
        send_tick(4'b1000, 2'd3, 1'b0);
        send_tick(4'b0000, 2'd3, 1'b1);
        send_tick(4'b0100, 2'd2, 1'b0);
        send_tick(4'b0100, 2'd2, 1'b0);
        send_tick(4'b0000, 2'd2, 1'b1);
        send_tick(4'b1111, 2'd0, 1'b0);
        send_tick(4'b1111, 2'd1, 1'b1);
        send_tick(4'b1111, 2'd2, 1'b1);
        send_tick(4'b1111, 2'd3, 1'b1);
        send_tick(4'b0000, 2'd0, 1'b0);
        levels_now = '0;

        base = sent;
        p = 0;
        while (sent - base < RANDOM_TICKS) begin
            budget = 200;
            for (int c = 0; c < bde_pkg::MAX_BTN; c++) lt[c] = 16'($urandom_range(1, 40));
            case (p)
                0: begin
                    db = 8'd3;
                    for (int c = 0; c < bde_pkg::MAX_BTN; c++) begin
                        lt[c] = 16'($urandom_range(0, 20));
                    end
                end
                1: begin
                    db = 8'd255;
                    for (int c = 0; c < bde_pkg::MAX_BTN; c++) begin
                        lt[c] = 16'($urandom_range(1, 8));
                    end
                    budget = 550;
                end
                2: begin
                    db = 8'd0;
                    for (int c = 0; c < bde_pkg::MAX_BTN; c++) begin
                        lt[c] = 16'($urandom_range(0, 3));
                    end
                end
                3: begin
                    db = 8'd1;
                    lt[$urandom_range(0, 3)] = 16'hFFFF;
                end
                default: begin
                    db = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
                    if ($urandom_range(0, 3) == 0) lt[$urandom_range(0, 3)] = 16'hFFFF;
                end
            endcase
            set_timing(db, lt);
            play_phase(db, budget);
            p++;
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("%0d ticks checked over %0d timing settings", checked_n, phases);
        $display("%0d clicks and %0d long presses predicted", clicks_n, longs_n);
        if (errors_n == 0 && outstanding_n == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bde_pkg.sv
hw/rtl/bde_chan.sv
hw/rtl/button_debounce_event_detector.sv
hw/rtl/bde_check.sv
tb/bde_checker.sv
tb/tb_top.sv
